// File: rtl/cfru_pkg.sv
// cfru_pkg: types and codes shared by the fault recognition unit
// no dependencies; imported by cpu_fault_recognition_unit_core, cfru_checker and tb
`timescale 1ns / 1ps

package cfru_pkg;

    localparam int NumFaults = 32;
    localparam int CodeW     = 5;
    localparam int SubW      = 16;
    localparam int FlagW     = 10;
    localparam int ChanW     = 3;

    typedef enum logic [2:0] {
        OP_RAISE       = 3'd0,
        OP_POST_G7     = 3'd1,
        OP_SERVICE_G7  = 3'd2,
        OP_CLEAR_TRO   = 3'd3,
        OP_CLEAR_TRB   = 3'd4
    } op_t;

    // fault numbers
    localparam logic [CodeW-1:0] F_STR = 5'd1;
    localparam logic [CodeW-1:0] F_TRO = 5'd4;
    localparam logic [CodeW-1:0] F_CON = 5'd8;
    localparam logic [CodeW-1:0] F_IPR = 5'd10;
    localparam logic [CodeW-1:0] F_ONC = 5'd11;
    localparam logic [CodeW-1:0] F_EXF = 5'd15;
    localparam logic [CodeW-1:0] F_ACV = 5'd20;
    localparam logic [CodeW-1:0] F_TRB = 5'd31;

    // subfault kinds
    localparam logic [3:0] K_NONE    = 4'd0;
    localparam logic [3:0] K_ILL_OP  = 4'd1;
    localparam logic [3:0] K_ILL_MOD = 4'd2;
    localparam logic [3:0] K_ILL_SLV = 4'd3;
    localparam logic [3:0] K_ILL_DIG = 4'd4;
    localparam logic [3:0] K_NEM     = 4'd6;
    localparam logic [3:0] K_OOB     = 4'd7;
    localparam logic [3:0] K_ILL_PTR = 4'd8;

    // cpu cycle codes
    localparam logic [2:0] CYC_FETCH  = 3'd1;
    localparam logic [2:0] CYC_FEXEC  = 3'd2;
    localparam logic [2:0] CYC_FEXEC2 = 3'd3;

    // sticky flag bit positions
    localparam int FL_ILL_OP   = 0;
    localparam int FL_ILL_MOD  = 1;
    localparam int FL_ILL_DIG  = 2;
    localparam int FL_ILL_PROC = 3;
    localparam int FL_NEM      = 4;
    localparam int FL_OOB      = 5;
    localparam int FL_CON_A    = 6;

    // input transaction, first field in the highest bits
    typedef struct packed {
        logic [2:0]       cpu_cycle;
        logic [SubW-1:0]  sub_value;
        logic [3:0]       sub_kind;
        logic [CodeW-1:0] fault_code;
        logic [2:0]       operation;
    } item_t;

    // result transaction, first field in the highest bits
    typedef struct packed {
        logic              g7_pending_other;
        logic              g7_pending;
        logic              cascade;
        logic              trouble_active;
        logic [FlagW-1:0]  fault_flags;
        logic [ChanW-1:0]  connect_channel;
        logic              fetch_flag;
        logic [SubW-1:0]   cu_flags;
        logic [SubW-1:0]   taken_sub;
        logic [CodeW-1:0]  taken_number;
        logic              fault_taken;
    } result_t;

endpackage

// File: rtl/cpu_fault_recognition_unit_core.sv
// cpu_fault_recognition_unit_core: fault recognition, group-7 posting and service
// depends on cfru_pkg
`timescale 1ns / 1ps

// Usage
//   s_ channel: one transaction per operation (raise, post group 7, service
//   group 7, clear timer runout, clear trouble). m_ channel: exactly one
//   result transaction per input transaction, in order.
//   The input is captured in an input register; the result is computed
//   from it and the fault state and loaded into the result register,
//   which drives m_tvalid.
//   Throughput is one transaction per cycle while m_tready is high: the
//   single flag and priority pass between the two registers sets that rate.
//   When m_tready is low the result register holds, the input register
//   still fills, and s_tready drops only when both are occupied.
//   Reset clears the sticky fault flags, trouble cycle, pending group-7 mask
//   and the posted connect subfault; both registers come up empty.
//   Only the connect entry of the posted subfault table is ever read back,
//   so only that entry is kept.

module cpu_fault_recognition_unit_core
    import cfru_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], fault_code[7:3], sub_kind[11:8], sub_value[27:12],
    // cpu_cycle[30:28], zero[31]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fault_taken[0], taken_number[5:1], taken_sub[21:6], cu_flags[37:22],
    // fetch_flag[38], connect_channel[41:39], fault_flags[51:42],
    // trouble_active[52], cascade[53], g7_pending[54], g7_pending_other[55]
    output logic [55:0] m_tdata
);

    logic                 in_valid_reg;
    item_t                in_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              out_next;

    logic [FlagW-1:0]     flag_reg, flag_next;
    logic                 trouble_reg, trouble_next;
    logic [NumFaults-1:0] pend_reg, pend_next;
    logic [SubW-1:0]      con_sub_reg, con_sub_next;

    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        logic             enter;
        logic [CodeW-1:0] num;
        logic [3:0]       kind;
        logic [SubW-1:0]  sub;
        logic [SubW-1:0]  cu;
        logic [ChanW-1:0] chan;
        logic             fexec;

        flag_next    = flag_reg;
        trouble_next = trouble_reg;
        pend_next    = pend_reg;
        con_sub_next = con_sub_reg;
        out_next     = '0;

        enter = 1'b0;
        num   = in_reg.fault_code;
        kind  = in_reg.sub_kind;
        sub   = in_reg.sub_value;
        chan  = '0;
        cu    = '0;
        fexec = (in_reg.cpu_cycle == CYC_FEXEC) || (in_reg.cpu_cycle == CYC_FEXEC2);

        case (in_reg.operation)
            OP_RAISE: begin
                enter = 1'b1;
            end
            OP_POST_G7: begin
                pend_next[in_reg.fault_code] = 1'b1;
                if (in_reg.fault_code == F_CON) begin
                    con_sub_next = in_reg.sub_value;
                end
            end
            OP_SERVICE_G7: begin
                enter = 1'b1;
                kind  = K_NONE;
                sub   = '0;
                // timer runout first, then connect, then execute
                if (pend_reg[F_TRO]) begin
                    num = F_TRO;
                    pend_next[F_TRO] = 1'b0;
                end else if (pend_reg[F_CON]) begin
                    num  = F_CON;
                    sub  = con_sub_reg;
                    chan = con_sub_reg[ChanW-1:0];
                    pend_next[F_CON] = 1'b0;
                end else if (pend_reg[F_EXF]) begin
                    num = F_EXF;
                    pend_next[F_EXF] = 1'b0;
                end else begin
                    num = F_TRB;
                end
            end
            OP_CLEAR_TRO: begin
                pend_next[F_TRO] = 1'b0;
            end
            OP_CLEAR_TRB: begin
                trouble_next = 1'b0;
            end
            default: begin
            end
        endcase

        if (enter) begin
            // sticky fault register
            if (num == F_IPR) begin
                if (kind == K_ILL_OP)       flag_next[FL_ILL_OP]   = 1'b1;
                else if (kind == K_ILL_MOD) flag_next[FL_ILL_MOD]  = 1'b1;
                else if (kind == K_ILL_DIG) flag_next[FL_ILL_DIG]  = 1'b1;
                else                        flag_next[FL_ILL_PROC] = 1'b1;
            end else if (num == F_ONC && kind == K_NEM) begin
                flag_next[FL_NEM] = 1'b1;
            end else if (num == F_STR && kind == K_OOB) begin
                flag_next[FL_OOB] = 1'b1;
            end else if (num == F_CON && sub[SubW-1:2] == '0) begin
                // connect channels a to d
                flag_next[FL_CON_A +: 4] = flag_next[FL_CON_A +: 4] | (4'b0001 << sub[1:0]);
            end

            // control unit violation flags
            if (num == F_ACV) begin
                cu = sub;
            end else if (num == F_STR) begin
                if (kind == K_OOB || kind == K_ILL_PTR) cu[6] = 1'b1;
            end else if (num == F_IPR) begin
                if (kind == K_ILL_OP)       cu[1] = 1'b1;
                else if (kind == K_ILL_MOD) cu[2] = 1'b1;
                else if (kind == K_ILL_SLV) cu[3] = 1'b1;
                else if (kind == K_ILL_DIG) cu[4] = 1'b1;
            end

            // fault during fault execute becomes trouble
            if (fexec) begin
                num = F_TRB;
                out_next.cascade = trouble_reg;
                trouble_next     = 1'b1;
            end else begin
                trouble_next = 1'b0;
            end
            if (num == F_TRB) begin
                sub = '0;
            end

            out_next.fault_taken     = 1'b1;
            out_next.taken_number    = num;
            out_next.taken_sub       = sub;
            out_next.cu_flags        = cu;
            out_next.fetch_flag      = (in_reg.cpu_cycle == CYC_FETCH);
            out_next.connect_channel = chan;
        end

        out_next.fault_flags      = flag_next;
        out_next.trouble_active   = trouble_next;
        out_next.g7_pending       = |pend_next;
        out_next.g7_pending_other = |(pend_next & ~(NumFaults'(1) << F_TRO));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
            trouble_reg   <= 1'b0;
            pend_reg      <= '0;
            con_sub_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                flag_reg      <= flag_next;
                trouble_reg   <= trouble_next;
                pend_reg      <= pend_next;
                con_sub_reg   <= con_sub_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= item_t'(s_tdata[30:0]);
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // a cascade only comes with a taken trouble fault
    a_cascade_trouble: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.cascade) |->
            (out_reg.fault_taken && out_reg.trouble_active
             && out_reg.taken_number == F_TRB))
        else $error("cascade without trouble fault");

    // no fault taken means quiet fault fields
    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.fault_taken) |->
            (out_reg.taken_number == '0 && out_reg.taken_sub == '0
             && out_reg.cu_flags == '0 && !out_reg.fetch_flag
             && out_reg.connect_channel == '0))
        else $error("fault fields set without fault taken");

    a_pending_other: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.g7_pending_other) |-> out_reg.g7_pending)
        else $error("pending other without pending");

    // sticky flags never clear outside reset
    a_flags_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ((flag_reg & $past(flag_reg)) == $past(flag_reg)))
        else $error("sticky fault flag cleared");
`endif

endmodule

// File: test/cfru_checker.sv
// cfru_checker: watches both channels of the fault recognition unit, predicts each result
// and compares it field by field; depends on cfru_pkg
`timescale 1ns / 1ps

module cfru_checker
    import cfru_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          outstanding,
    output int          results_seen,
    output int          faults_entered,
    output int          cascades_seen
);

    // control unit word 1 bit positions
    localparam int CU_ILL_OP  = 1;
    localparam int CU_ILL_MOD = 2;
    localparam int CU_ILL_SLV = 3;
    localparam int CU_ILL_DIG = 4;
    localparam int CU_OOB_PTR = 6;

    logic [FlagW-1:0]     sticky_flags;
    logic                 in_trouble;
    logic [NumFaults-1:0] g7_mask;
    logic [SubW-1:0]      g7_sub [NumFaults];
    result_t              outcome_q [$];

    initial begin
        fail_count     = 0;
        outstanding    = 0;
        results_seen   = 0;
        faults_entered = 0;
        cascades_seen  = 0;
        sticky_flags   = '0;
        in_trouble     = 1'b0;
        g7_mask        = '0;
        foreach (g7_sub[i]) g7_sub[i] = '0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("[%0t] result %0d %s: got 0x%0h expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    // fault entry: sticky flags, cu word, trouble conversion
    function automatic result_t enter_fault(logic [CodeW-1:0] code, logic [3:0] kind,
                                            logic [SubW-1:0] value, logic [2:0] cycle);
        result_t          r;
        logic [CodeW-1:0] num;
        logic [SubW-1:0]  sub;
        logic [SubW-1:0]  cu;
        r   = '0;
        num = code;
        sub = value;
        cu  = '0;

        if (num == F_IPR) begin
            case (kind)
                K_ILL_OP:  sticky_flags[FL_ILL_OP]   = 1'b1;
                K_ILL_MOD: sticky_flags[FL_ILL_MOD]  = 1'b1;
                K_ILL_DIG: sticky_flags[FL_ILL_DIG]  = 1'b1;
                default:   sticky_flags[FL_ILL_PROC] = 1'b1;
            endcase
        end else if (num == F_ONC && kind == K_NEM) begin
            sticky_flags[FL_NEM] = 1'b1;
        end else if (num == F_STR && kind == K_OOB) begin
            sticky_flags[FL_OOB] = 1'b1;
        end else if (num == F_CON && sub < 16'd4) begin
            sticky_flags[FL_CON_A +: 4] = sticky_flags[FL_CON_A +: 4] | (4'b0001 << sub[1:0]);
        end

        if (num == F_ACV) begin
            cu = sub;
        end else if (num == F_STR) begin
            if (kind == K_OOB || kind == K_ILL_PTR) cu[CU_OOB_PTR] = 1'b1;
        end else if (num == F_IPR) begin
            case (kind)
                K_ILL_OP:  cu[CU_ILL_OP]  = 1'b1;
                K_ILL_MOD: cu[CU_ILL_MOD] = 1'b1;
                K_ILL_SLV: cu[CU_ILL_SLV] = 1'b1;
                K_ILL_DIG: cu[CU_ILL_DIG] = 1'b1;
                default: ;
            endcase
        end

        r.fetch_flag = (cycle == CYC_FETCH);
        // any fault in a fault-execute cycle becomes trouble
        if (cycle == CYC_FEXEC || cycle == CYC_FEXEC2) begin
            num = F_TRB;
            if (in_trouble) r.cascade = 1'b1;
            else in_trouble = 1'b1;
        end else begin
            in_trouble = 1'b0;
        end
        if (num == F_TRB) sub = '0;

        r.fault_taken  = 1'b1;
        r.taken_number = num;
        r.taken_sub    = sub;
        r.cu_flags     = cu;
        return r;
    endfunction

    function automatic result_t predict_outcome(item_t it);
        result_t              r;
        logic [SubW-1:0]      con_sub;
        logic [NumFaults-1:0] others;
        r = '0;
        case (it.operation)
            OP_RAISE:
                r = enter_fault(it.fault_code, it.sub_kind, it.sub_value, it.cpu_cycle);
            OP_POST_G7: begin
                g7_mask[it.fault_code] = 1'b1;
                g7_sub[it.fault_code]  = it.sub_value;
            end
            OP_SERVICE_G7: begin
                // priority: timer runout, connect, execute, else trouble
                if (g7_mask[F_TRO]) begin
                    g7_mask[F_TRO] = 1'b0;
                    r = enter_fault(F_TRO, K_NONE, '0, it.cpu_cycle);
                end else if (g7_mask[F_CON]) begin
                    con_sub        = g7_sub[F_CON];
                    g7_mask[F_CON] = 1'b0;
                    r = enter_fault(F_CON, K_NONE, con_sub, it.cpu_cycle);
                    r.connect_channel = con_sub[ChanW-1:0];
                end else if (g7_mask[F_EXF]) begin
                    g7_mask[F_EXF] = 1'b0;
                    r = enter_fault(F_EXF, K_NONE, '0, it.cpu_cycle);
                end else begin
                    r = enter_fault(F_TRB, K_NONE, '0, it.cpu_cycle);
                end
            end
            OP_CLEAR_TRO: g7_mask[F_TRO] = 1'b0;
            OP_CLEAR_TRB: in_trouble = 1'b0;
            default: ;
        endcase
        others         = g7_mask;
        others[F_TRO]  = 1'b0;
        r.fault_flags      = sticky_flags;
        r.trouble_active   = in_trouble;
        r.g7_pending       = |g7_mask;
        r.g7_pending_other = |others;
        return r;
    endfunction

    task automatic compare_result(result_t got, result_t want);
        if (got.fault_taken !== want.fault_taken)
            report_mismatch("fault_taken", 32'(got.fault_taken), 32'(want.fault_taken));
        if (got.taken_number !== want.taken_number)
            report_mismatch("taken_number", 32'(got.taken_number), 32'(want.taken_number));
        if (got.taken_sub !== want.taken_sub)
            report_mismatch("taken_sub", 32'(got.taken_sub), 32'(want.taken_sub));
        if (got.cu_flags !== want.cu_flags)
            report_mismatch("cu_flags", 32'(got.cu_flags), 32'(want.cu_flags));
        if (got.fetch_flag !== want.fetch_flag)
            report_mismatch("fetch_flag", 32'(got.fetch_flag), 32'(want.fetch_flag));
        if (got.connect_channel !== want.connect_channel)
            report_mismatch("connect_channel", 32'(got.connect_channel),
                            32'(want.connect_channel));
        if (got.fault_flags !== want.fault_flags)
            report_mismatch("fault_flags", 32'(got.fault_flags), 32'(want.fault_flags));
        if (got.trouble_active !== want.trouble_active)
            report_mismatch("trouble_active", 32'(got.trouble_active),
                            32'(want.trouble_active));
        if (got.cascade !== want.cascade)
            report_mismatch("cascade", 32'(got.cascade), 32'(want.cascade));
        if (got.g7_pending !== want.g7_pending)
            report_mismatch("g7_pending", 32'(got.g7_pending), 32'(want.g7_pending));
        if (got.g7_pending_other !== want.g7_pending_other)
            report_mismatch("g7_pending_other", 32'(got.g7_pending_other),
                            32'(want.g7_pending_other));
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            sticky_flags = '0;
            in_trouble   = 1'b0;
            g7_mask      = '0;
            foreach (g7_sub[i]) g7_sub[i] = '0;
            outcome_q.delete();
            outstanding = 0;
        end else begin
            // retire the result before queuing a new transaction at the same edge
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                results_seen++;
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", m_tdata[31:0], '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (want.fault_taken) faults_entered++;
                    if (want.cascade) cascades_seen++;
                    compare_result(got, want);
                end
            end
            if (s_tvalid && s_tready)
                outcome_q.push_back(predict_outcome(item_t'(s_tdata[30:0])));
            outstanding = outcome_q.size();
        end
    end

endmodule

// File: test/tb.sv
// tb: stimulus and verdict for cpu_fault_recognition_unit_core
// depends on cfru_pkg, the core and cfru_checker
`timescale 1ns / 1ps

module tb;
    import cfru_pkg::*;

    localparam int          RANDOM_ITEMS = 1150;
    localparam int          HOLD_CYCLES  = 60;
    localparam logic [2:0]  CYC_EXEC     = 3'd0;
    localparam logic [2:0]  CYC_OTHER    = 3'd4;
    localparam logic [2:0]  CYC_BOGUS    = 3'd7;
    localparam logic [3:0]  K_BOGUS      = 4'd15;
    localparam logic [2:0]  OP_RESERVED  = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [55:0] m_tdata;

    int fail_count;
    int outstanding;
    int results_seen;
    int faults_entered;
    int cascades_seen;
    int items_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_left    = 0;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;

    always #1 aclk = ~aclk;

    cpu_fault_recognition_unit_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cfru_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .faults_entered (faults_entered),
        .cascades_seen  (cascades_seen)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(item_t it);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_fields(logic [2:0] op, logic [CodeW-1:0] code, logic [3:0] kind,
                               logic [SubW-1:0] value, logic [2:0] cycle);
        item_t it;
        it.operation  = op;
        it.fault_code = code;
        it.sub_kind   = kind;
        it.sub_value  = value;
        it.cpu_cycle  = cycle;
        send_item(it);
    endtask

    // mostly meaningful operations; stray group-7 codes only when allowed,
    // since they stay pending for the rest of the run
    function automatic item_t random_item(bit stray_posts);
        item_t it;
        int    pick;
        it.fault_code = CodeW'($urandom_range(31));
        it.sub_value  = SubW'($urandom);
        it.sub_kind   = ($urandom_range(9) < 7) ? 4'($urandom_range(8))
                                                : 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 50)      it.cpu_cycle = 3'($urandom_range(1));
        else if (pick < 75) it.cpu_cycle = 3'($urandom_range(3, 2));
        else                it.cpu_cycle = 3'($urandom_range(7, 4));

        pick = $urandom_range(99);
        if (pick < 40) begin
            it.operation = OP_RAISE;
            if ($urandom_range(9) < 6) begin
                case ($urandom_range(5))
                    0: it.fault_code = F_STR;
                    1: it.fault_code = F_CON;
                    2: it.fault_code = F_IPR;
                    3: it.fault_code = F_ONC;
                    4: it.fault_code = F_ACV;
                    default: it.fault_code = F_TRB;
                endcase
            end
        end else if (pick < 55) begin
            it.operation = OP_POST_G7;
            if (!(stray_posts && $urandom_range(19) == 0)) begin
                case ($urandom_range(2))
                    0: it.fault_code = F_TRO;
                    1: it.fault_code = F_CON;
                    default: it.fault_code = F_EXF;
                endcase
            end
        end else if (pick < 78) begin
            it.operation = OP_SERVICE_G7;
        end else if (pick < 86) begin
            it.operation = OP_CLEAR_TRO;
        end else if (pick < 95) begin
            it.operation = OP_CLEAR_TRB;
        end else begin
            it.operation = 3'($urandom_range(7, 5));
        end

        // small connect subfaults reach the channel flags
        if (it.fault_code == F_CON && $urandom_range(1) == 0)
            it.sub_value = SubW'($urandom_range(7));
        return it;
    endfunction

    initial begin
        int waited;
        waited = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 6;
        rx_idle_pct = 65;

        // every subfault kind of an illegal procedure, plus an unnamed kind
        send_fields(OP_RAISE, F_IPR, K_ILL_OP, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, F_IPR, K_ILL_MOD, 16'h0001, CYC_FETCH);
        send_fields(OP_RAISE, F_IPR, K_ILL_SLV, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, F_IPR, K_ILL_DIG, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, F_IPR, K_BOGUS, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, F_ONC, K_NEM, 16'h1234, CYC_EXEC);
        send_fields(OP_RAISE, F_STR, K_OOB, 16'h0000, CYC_FETCH);
        send_fields(OP_RAISE, F_STR, K_ILL_PTR, 16'hFFFF, CYC_EXEC);
        send_fields(OP_RAISE, F_ACV, K_NONE, 16'hFFFF, CYC_EXEC);
        send_fields(OP_RAISE, F_CON, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, F_CON, K_NONE, 16'h0003, CYC_OTHER);
        // trouble, then a cascade, then leave the trouble cycle
        send_fields(OP_RAISE, F_ACV, K_NONE, 16'hA5A5, CYC_FEXEC);
        send_fields(OP_RAISE, F_IPR, K_ILL_OP, 16'h0000, CYC_FEXEC2);
        send_fields(OP_CLEAR_TRB, 5'd0, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_RAISE, 5'd0, K_NONE, 16'h0000, CYC_BOGUS);
        // service with nothing pending
        send_fields(OP_SERVICE_G7, 5'd0, K_NONE, 16'h0000, CYC_EXEC);
        // posted faults come back in priority order
        send_fields(OP_POST_G7, F_EXF, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_POST_G7, F_CON, K_NONE, 16'hFFFD, CYC_EXEC);
        send_fields(OP_POST_G7, F_TRO, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_CLEAR_TRO, 5'd0, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_POST_G7, F_TRO, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_SERVICE_G7, 5'd0, K_NONE, 16'h0000, CYC_FETCH);
        send_fields(OP_SERVICE_G7, 5'd0, K_NONE, 16'h0000, CYC_EXEC);
        send_fields(OP_SERVICE_G7, 5'd0, K_NONE, 16'h0000, CYC_OTHER);
        // service in a fault-execute cycle turns into trouble
        send_fields(OP_POST_G7, F_CON, K_NONE, 16'h0002, CYC_EXEC);
        send_fields(OP_SERVICE_G7, 5'd0, K_NONE, 16'h0000, CYC_FEXEC);
        send_fields(OP_RESERVED, 5'd31, K_BOGUS, 16'hFFFF, CYC_BOGUS);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_idle_pct  = 0;
                    hold_request <= 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_item(random_item(phase == 2));
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (4) @(negedge aclk);

        $display("covered %0d operations and %0d results: %0d faults entered, %0d cascades",
                 items_sent, results_seen, faults_entered, cascades_seen);
        $display("both sides stalled at random, plus a %0d-cycle result hold-off", HOLD_CYCLES);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
